FILE: src/dsr_pkg.sv
// Package for the display slot reservation block.
// Holds item structs, slot entry layout, status codes and default sizes.
// No dependencies.
package dsr_pkg;

    localparam int DISPLAYS_DEF = 16;
    localparam int SLOTS_DEF    = 16;

    localparam int TIME_W = 12;   // decimal HHMM start and now values
    localparam int LEN_W  = 11;   // length in minutes
    localparam int SUM_W  = 14;   // end time after digit-carry addition
    localparam int DISP_W = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOW     = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [DISP_W-1:0] display_index;
        logic [TIME_W-1:0] start_hhmm;
        logic [LEN_W-1:0]  length_minutes;
        logic [TIME_W-1:0] now_hhmm;
        logic              commit;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SUM_W-1:0]  suggested_time;
        logic [DISP_W-1:0] display_echo;
    } t_rsp;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } t_slot;

    // Request and result of the end time adder
    typedef struct packed {
        logic              go;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] d;
    } t_tadd_in;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } t_tadd_out;

endpackage

FILE: src/dsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dsr_time_add.sv
// Four-stage pipeline for decimal HHMM plus minutes with per-digit carries.
// Depends on dsr_pkg for widths and the adder request/result structs.
module dsr_time_add
    import dsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tadd_in  i_in,
    output t_tadd_out o_out
);

    // digit of x in units of step, found by parallel compares (x below 10 steps)
    function automatic logic [3:0] f_digit(input logic [TIME_W-1:0] x,
                                           input logic [TIME_W-1:0] step);
        logic [3:0] v_d;
        v_d = '0;
        for (int k = 1; k < 10; k++) begin
            if ({4'b0, x} >= (16'(k) * {4'b0, step})) begin
                v_d = 4'(k);
            end
        end
        return v_d;
    endfunction

    logic [3:0] r_v;

    // stage 1
    logic [3:0]        r1_th;
    logic [9:0]        r1_rem;
    logic [TIME_W-1:0] r1_d;
    logic [6:0]        r1_q;
    // stage 2
    logic [3:0]        r2_th, r2_hu;
    logic [6:0]        r2_rem;
    logic [5:0]        r2_mn;
    logic [6:0]        r2_q;
    // stage 3
    logic [3:0]        r3_th, r3_hu, r3_te, r3_un;
    logic [3:0]        r3_mt, r3_mu, r3_ht, r3_hr;
    // stage 4
    logic [SUM_W-1:0]  r4_sum;

    logic [3:0]        s1_th;
    logic [23:0]       s1_prod;
    logic [3:0]        s2_hu;
    logic [3:0]        s3_te, s3_mt, s3_ht;

    // split thousands, and hours = d / 60 by reciprocal multiply (exact below 4681)
    assign s1_th   = f_digit(i_in.t, 12'd1000);
    assign s1_prod = 24'(i_in.d) * 24'd2185;

    assign s2_hu = f_digit({2'b0, r1_rem}, 12'd100);

    assign s3_te = f_digit({5'b0, r2_rem}, 12'd10);
    assign s3_mt = f_digit({6'b0, r2_mn}, 12'd10);
    assign s3_ht = f_digit({5'b0, r2_q}, 12'd10);

    // add digits with carries: units at 10, tens at 6, hours at 10
    logic [4:0]  s4_s0, s4_s1, s4_s2;
    logic [3:0]  s4_un, s4_te, s4_hu;
    logic [1:0]  s4_c1, s4_c2;
    logic        s4_c0;
    logic [4:0]  s4_th;
    always_comb begin
        s4_s0 = 5'(r3_un) + 5'(r3_mu);
        s4_c0 = (s4_s0 >= 5'd10);
        s4_un = s4_c0 ? 4'(s4_s0 - 5'd10) : s4_s0[3:0];

        s4_s1 = 5'(r3_te) + 5'(r3_mt) + 5'(s4_c0);
        if (s4_s1 >= 5'd12) begin
            s4_c1 = 2'd2;
            s4_te = 4'(s4_s1 - 5'd12);
        end else if (s4_s1 >= 5'd6) begin
            s4_c1 = 2'd1;
            s4_te = 4'(s4_s1 - 5'd6);
        end else begin
            s4_c1 = 2'd0;
            s4_te = s4_s1[3:0];
        end

        s4_s2 = 5'(r3_hu) + 5'(r3_hr) + 5'(s4_c1);
        if (s4_s2 >= 5'd20) begin
            s4_c2 = 2'd2;
            s4_hu = 4'(s4_s2 - 5'd20);
        end else if (s4_s2 >= 5'd10) begin
            s4_c2 = 2'd1;
            s4_hu = 4'(s4_s2 - 5'd10);
        end else begin
            s4_c2 = 2'd0;
            s4_hu = s4_s2[3:0];
        end

        s4_th = 5'(r3_th) + 5'(r3_ht) + 5'(s4_c2);
    end

    // advance valid marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_in.go};
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r1_th  <= s1_th;
        r1_rem <= 10'(i_in.t - 12'(s1_th) * 12'd1000);
        r1_d   <= i_in.d;
        r1_q   <= s1_prod[23:17];

        r2_th  <= r1_th;
        r2_hu  <= s2_hu;
        r2_rem <= 7'(r1_rem - 10'(s2_hu) * 10'd100);
        r2_mn  <= 6'(r1_d - 12'(r1_q) * 12'd60);
        r2_q   <= r1_q;

        r3_th  <= r2_th;
        r3_hu  <= r2_hu;
        r3_te  <= s3_te;
        r3_un  <= 4'(r2_rem - 7'(s3_te) * 7'd10);
        r3_mt  <= s3_mt;
        r3_mu  <= 4'(r2_mn - 6'(s3_mt) * 6'd10);
        r3_ht  <= s3_ht;
        r3_hr  <= 4'(r2_q - 7'(s3_ht) * 7'd10);

        r4_sum <= SUM_W'(16'(s4_th) * 16'd1000 + 16'(s4_hu) * 16'd100
                         + 16'(s4_te) * 16'd10 + 16'(s4_un));
    end

    assign o_out.done = r_v[3];
    assign o_out.sum  = r4_sum;

endmodule

FILE: src/display_slot_reservation.sv
// Top level of the display slot reservation block.
// Depends on dsr_pkg, dsr_ram and dsr_time_add.
//
// One request is handled at a time; o_ready is high only while no request is in
// work. A request rejected as not after now or as full goes from the check
// state straight to the output hand-off. A placed or overlapping request first
// computes its end in the end time adder, then walks the display's slots from
// the front, with one RAM read per slot and one adder pass for each slot it
// passes over, plus one more adder pass for the suggestion on overlap. A commit
// that lands before an existing slot moves each later slot up one place, with a
// read state and a write state per slot, then writes the new slot. The slot RAM
// has one write and one read port. The result waits in an output register; slot
// counts reset to zero, slot contents need no clearing pass.
module display_slot_reservation
    import dsr_pkg::*;
#(
    parameter int DISPLAYS          = DISPLAYS_DEF,
    parameter int SLOTS_PER_DISPLAY = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    // only 16 displays are reachable through a 4-bit index
    localparam int DEFF  = (DISPLAYS < (1 << DISP_W)) ? DISPLAYS : (1 << DISP_W);
    localparam int DIW   = (DEFF > 1) ? $clog2(DEFF) : 1;
    localparam int SW    = $clog2(SLOTS_PER_DISPLAY);
    localparam int CW    = $clog2(SLOTS_PER_DISPLAY + 1);
    localparam int DEPTH = DEFF * SLOTS_PER_DISPLAY;
    localparam int AW    = $clog2(DEPTH);
    localparam int AXW   = AW + DIW + SW + 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CHECK    = 11'b000_0000_0010,
        S_NEW_END  = 11'b000_0000_0100,
        S_READ     = 11'b000_0000_1000,
        S_TEST     = 11'b000_0001_0000,
        S_END_WAIT = 11'b000_0010_0000,
        S_SUG_WAIT = 11'b000_0100_0000,
        S_SHIFT_RD = 11'b000_1000_0000,
        S_SHIFT_WR = 11'b001_0000_0000,
        S_PUT      = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [SW-1:0]     r_n, n_n;
    logic [SW-1:0]     r_i, n_i;
    logic [SW-1:0]     r_pos, n_pos;
    logic [SW-1:0]     r_k, n_k;
    logic [SUM_W-1:0]  r_new_end, n_new_end;
    logic [SUM_W-1:0]  r_prev_end, n_prev_end;
    t_slot             r_cur, n_cur;
    t_status           r_status, n_status;
    logic [SUM_W-1:0]  r_sugg, n_sugg;
    t_rsp              r_out, n_out;
    logic              r_ov, n_ov;
    logic [CW-1:0]     r_count [DEFF];

    logic              v_count_we;
    logic [DIW-1:0]    disp_idx;
    logic              disp_oor;
    logic [CW-1:0]     cur_count;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_slot             ram_wdata, ram_rdata;

    t_tadd_in          tadd_in;
    t_tadd_out         tadd_out;

    logic [SUM_W-1:0]  st_ext, s_ext;
    logic              v_place;
    logic [SW-1:0]     v_pos;

    // flat RAM address of a display's slot
    function automatic logic [AW-1:0] f_addr(input logic [DIW-1:0] disp,
                                             input logic [SW-1:0] slot);
        return AW'(AXW'(disp) * AXW'(SLOTS_PER_DISPLAY) + AXW'(slot));
    endfunction

    assign disp_idx  = r_req.display_index[DIW-1:0];
    assign disp_oor  = (9'(r_req.display_index) >= 9'(DISPLAYS));
    assign cur_count = r_count[disp_idx];
    assign st_ext    = SUM_W'(r_req.start_hhmm);
    assign s_ext     = SUM_W'(ram_rdata.start);

    dsr_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dsr_time_add u_time_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tadd_in),
        .o_out   (tadd_out)
    );

    // sequence one request: check, walk, shift, insert, report
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_n        = r_n;
        n_i        = r_i;
        n_pos      = r_pos;
        n_k        = r_k;
        n_new_end  = r_new_end;
        n_prev_end = r_prev_end;
        n_cur      = r_cur;
        n_status   = r_status;
        n_sugg     = r_sugg;
        n_out      = r_out;
        n_ov       = r_ov;
        v_count_we = 1'b0;
        v_place    = 1'b0;
        v_pos      = '0;
        ram_we     = 1'b0;
        ram_waddr  = f_addr(disp_idx, r_pos);
        ram_wdata  = '{start: r_req.start_hhmm, length: r_req.length_minutes};
        ram_raddr  = f_addr(disp_idx, r_i);
        tadd_in    = '{go: 1'b0, t: r_req.start_hhmm, d: TIME_W'(r_req.length_minutes)};

        // drop the output item once taken
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_req.now_hhmm >= r_req.start_hhmm) begin
                    n_status = ST_NOW;
                    n_sugg   = SUM_W'(r_req.now_hhmm);
                    n_state  = S_DONE;
                end else if (disp_oor || (cur_count >= CW'(SLOTS_PER_DISPLAY))) begin
                    n_status = ST_FULL;
                    n_sugg   = st_ext;
                    n_state  = S_DONE;
                end else begin
                    tadd_in.go = 1'b1;
                    n_n        = cur_count[SW-1:0];
                    n_i        = '0;
                    n_state    = S_NEW_END;
                end
            end
            S_NEW_END: begin
                if (tadd_out.done) begin
                    n_new_end = tadd_out.sum;
                    if (r_n == '0) begin
                        v_place = 1'b1;
                        v_pos   = '0;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                n_cur = ram_rdata;
                if ((s_ext >= r_new_end) && ((r_i == '0) || (st_ext >= r_prev_end))) begin
                    v_place = 1'b1;
                    v_pos   = r_i;
                end else begin
                    tadd_in = '{go: 1'b1, t: ram_rdata.start,
                                d: TIME_W'(ram_rdata.length)};
                    n_state = S_END_WAIT;
                end
            end
            S_END_WAIT: begin
                if (tadd_out.done) begin
                    n_prev_end = tadd_out.sum;
                    if (r_i == SW'(r_n - 1'b1)) begin
                        if (st_ext >= tadd_out.sum) begin
                            v_place = 1'b1;
                            v_pos   = r_n;
                        end else begin
                            tadd_in = '{go: 1'b1, t: r_cur.start,
                                        d: TIME_W'(r_cur.length) + 1'b1};
                            n_state = S_SUG_WAIT;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_SUG_WAIT: begin
                if (tadd_out.done) begin
                    n_status = ST_OVERLAP;
                    n_sugg   = tadd_out.sum;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = f_addr(disp_idx, r_k);
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(disp_idx, r_k + 1'b1);
                ram_wdata = ram_rdata;
                if (r_k == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_SHIFT_RD;
                end
            end
            S_PUT: begin
                ram_we     = 1'b1;
                v_count_we = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_out   = '{status: r_status, suggested_time: r_sugg,
                                display_echo: r_req.display_index};
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // accept the slot at v_pos; insert only on commit
        if (v_place) begin
            n_status = ST_OK;
            n_sugg   = st_ext;
            n_pos    = v_pos;
            if (!r_req.commit) begin
                n_state = S_DONE;
            end else if (v_pos < r_n) begin
                n_k     = SW'(r_n - 1'b1);
                n_state = S_SHIFT_RD;
            end else begin
                n_state = S_PUT;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // per-display slot counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEFF; d++) begin
                r_count[d] <= '0;
            end
        end else if (v_count_we) begin
            r_count[disp_idx] <= CW'(r_n) + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_n        <= n_n;
        r_i        <= n_i;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_new_end  <= n_new_end;
        r_prev_end <= n_prev_end;
        r_cur      <= n_cur;
        r_status   <= n_status;
        r_sugg     <= n_sugg;
        r_out      <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_rsp   = r_out;

endmodule
